### design/pgmnak_pkg.sv
// pgmnak_pkg: constants, verdict codes and ones-complement helper for the
// PGM NAK overflow detector. No dependencies.
`default_nettype none

package pgmnak_pkg;

    localparam int unsigned COUNT_W = 16;

    // Byte offsets inside the PGM header
    localparam logic [COUNT_W-1:0] OFF_TYPE     = 16'd4;
    localparam logic [COUNT_W-1:0] OFF_CK_HI    = 16'd6;
    localparam logic [COUNT_W-1:0] OFF_CK_LO    = 16'd7;
    localparam logic [COUNT_W-1:0] OFF_OPT_TYPE = 16'd36;
    localparam logic [COUNT_W-1:0] OFF_OPT_LEN  = 16'd37;
    localparam logic [COUNT_W-1:0] HEADER_BYTES = 16'd44;
    localparam logic [COUNT_W-1:0] DATA_BASE    = 16'd36;
    localparam logic [1:0]         ALIGN_MASK   = 2'h3;

    localparam logic [7:0] NAK_TYPE     = 8'd8;
    localparam logic [7:0] NAK_OPT_VULN = 8'd2;

    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    typedef logic [1:0] verdict_t;
    localparam verdict_t V_MALFORMED = 2'd0;
    localparam verdict_t V_OK        = 2'd1;
    localparam verdict_t V_OVERFLOW  = 2'd2;

    // One byte beat handed from the input stage to the packet tracker
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    // 16-bit ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

`default_nettype wire

### design/pgmnak_tracker.sv
// pgmnak_tracker: per-packet state (count, checksum sum, captured header
// fields) and the end-of-packet verdict. Depends on pgmnak_pkg.
`default_nettype none

module pgmnak_tracker #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      step,
    input  wire pgmnak_pkg::beat_t   beat,
    output pgmnak_pkg::verdict_t     verdict
);

    localparam logic [pgmnak_pkg::COUNT_W-1:0] MAX_CNT =
        pgmnak_pkg::COUNT_W'(MAX_PACKET_BYTES);
    localparam logic [pgmnak_pkg::COUNT_W-1:0] CNT_ONE =
        pgmnak_pkg::COUNT_W'(1);

    logic [pgmnak_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next, upd_count;
    logic [15:0] sum_reg, sum_next, upd_sum;
    logic [7:0]  high_hold_reg, high_hold_next, upd_high;
    logic        type_nak_reg, type_nak_next, upd_type_nak;
    logic        opt_two_reg, opt_two_next, upd_opt_two;
    logic [7:0]  opt_len_reg, opt_len_next, upd_opt_len;
    logic        ck_nz_reg, ck_nz_next, upd_ck_nz;
    logic        len_ovf_reg, len_ovf_next, upd_len_ovf;
    logic [pgmnak_pkg::COUNT_W-1:0] pos;

    // Field capture and sum update for this byte
    always_comb
    begin
        pos          = byte_count_reg;
        upd_count    = byte_count_reg;
        upd_sum      = sum_reg;
        upd_high     = high_hold_reg;
        upd_type_nak = type_nak_reg;
        upd_opt_two  = opt_two_reg;
        upd_opt_len  = opt_len_reg;
        upd_ck_nz    = ck_nz_reg;
        upd_len_ovf  = len_ovf_reg;
        if (!len_ovf_reg)
        begin
            if (pos == pgmnak_pkg::OFF_TYPE)
                upd_type_nak = (beat.data == pgmnak_pkg::NAK_TYPE);
            if ((pos == pgmnak_pkg::OFF_CK_HI || pos == pgmnak_pkg::OFF_CK_LO)
                && beat.data != 8'd0)
                upd_ck_nz = 1'b1;
            if (pos == pgmnak_pkg::OFF_OPT_TYPE)
                upd_opt_two = (beat.data == pgmnak_pkg::NAK_OPT_VULN);
            if (pos == pgmnak_pkg::OFF_OPT_LEN)
                upd_opt_len = beat.data;
            if (!pos[0])
                upd_high = beat.data;
            else
                upd_sum = pgmnak_pkg::oc_add(sum_reg, {high_hold_reg, beat.data});
            if (byte_count_reg >= MAX_CNT)
                upd_len_ovf = 1'b1;
            else
                upd_count = byte_count_reg + CNT_ONE;
        end
    end

    // Verdict on the updated state
    always_comb
    begin
        if (upd_len_ovf)
            verdict = pgmnak_pkg::V_MALFORMED;
        else if (upd_count <= pgmnak_pkg::HEADER_BYTES
                 || (upd_count[1:0] & pgmnak_pkg::ALIGN_MASK) != 2'd0)
            verdict = pgmnak_pkg::V_MALFORMED;
        else if (!upd_type_nak || !upd_opt_two)
            verdict = pgmnak_pkg::V_MALFORMED;
        else if ((upd_count - pgmnak_pkg::DATA_BASE) > {8'd0, upd_opt_len})
        begin
            if (upd_ck_nz && upd_sum != pgmnak_pkg::SUM_GOOD)
                verdict = pgmnak_pkg::V_MALFORMED;
            else
                verdict = pgmnak_pkg::V_OVERFLOW;
        end
        else
            verdict = pgmnak_pkg::V_OK;
    end

    // Commit; last byte clears everything for the next packet
    always_comb
    begin
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        high_hold_next  = high_hold_reg;
        type_nak_next   = type_nak_reg;
        opt_two_next    = opt_two_reg;
        opt_len_next    = opt_len_reg;
        ck_nz_next      = ck_nz_reg;
        len_ovf_next    = len_ovf_reg;
        if (step)
        begin
            if (beat.last)
            begin
                byte_count_next = '0;
                sum_next        = '0;
                high_hold_next  = '0;
                type_nak_next   = 1'b0;
                opt_two_next    = 1'b0;
                opt_len_next    = '0;
                ck_nz_next      = 1'b0;
                len_ovf_next    = 1'b0;
            end
            else
            begin
                byte_count_next = upd_count;
                sum_next        = upd_sum;
                high_hold_next  = upd_high;
                type_nak_next   = upd_type_nak;
                opt_two_next    = upd_opt_two;
                opt_len_next    = upd_opt_len;
                ck_nz_next      = upd_ck_nz;
                len_ovf_next    = upd_len_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            high_hold_reg  <= '0;
            type_nak_reg   <= 1'b0;
            opt_two_reg    <= 1'b0;
            opt_len_reg    <= '0;
            ck_nz_reg      <= 1'b0;
            len_ovf_reg    <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            high_hold_reg  <= high_hold_next;
            type_nak_reg   <= type_nak_next;
            opt_two_reg    <= opt_two_next;
            opt_len_reg    <= opt_len_next;
            ck_nz_reg      <= ck_nz_next;
            len_ovf_reg    <= len_ovf_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_CNT)
        else $error("byte count past maximum");

    a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        len_ovf_reg |-> byte_count_reg == MAX_CNT)
        else $error("overflow flag without saturated count");

    a_type_after_offset: assert property (@(posedge clk) disable iff (!rst_n)
        type_nak_reg |-> byte_count_reg > pgmnak_pkg::OFF_TYPE)
        else $error("type captured before its offset");

endmodule

`default_nettype wire

### design/pgm_nak_overflow_detector.sv
// pgm_nak_overflow_detector: top level. Input stage, packet tracker and
// verdict output register. Depends on pgmnak_pkg and pgmnak_tracker.
`default_nettype none

// Channel   Handshake            Payload                       Notes
// in        in_valid/in_ready    packet_byte[7:0], last_byte   one beat per byte
// out       out_valid/out_ready  verdict[1:0]                  one beat per packet
//
// Throughput: one byte per clock unless a last byte waits on a full output.
// Verdict path: the accepted last byte is registered in the input stage, and
//   its verdict is registered in the output register when the byte advances.
// Reset: rst_n clears all packet state and both valid flags.
// Stalls: non-last bytes flow past a blocked output; only a last byte waits
//   in the input stage while an earlier verdict is still untaken.
module pgm_nak_overflow_detector #(
    parameter int unsigned MAX_PACKET_BYTES = 65535
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire  [7:0] packet_byte,
    input  wire        last_byte,
    output logic       out_valid,
    input  wire        out_ready,
    output logic [1:0] verdict
);

    // Input stage
    logic              stage_valid_reg, stage_valid_next;
    pgmnak_pkg::beat_t stage_beat_reg, stage_beat_next;
    logic              advance;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    pgmnak_pkg::verdict_t verdict_reg, verdict_next;
    pgmnak_pkg::verdict_t trk_verdict;

    // A staged byte moves on unless it is last and the output is full, not ready
    assign advance  = stage_valid_reg
                      && (!stage_beat_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_beat_next  = stage_beat_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next     = 1'b1;
            stage_beat_next.data = packet_byte;
            stage_beat_next.last = last_byte;
        end
        else if (advance)
            stage_valid_next = 1'b0;
    end

    pgmnak_tracker #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .beat    (stage_beat_reg),
        .verdict (trk_verdict)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        if (advance && stage_beat_reg.last)
        begin
            out_valid_next = 1'b1;
            verdict_next   = trk_verdict;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        stage_beat_reg <= stage_beat_next;
        verdict_reg    <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    a_block_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_valid_reg && stage_beat_reg.last
                      && out_valid_reg && !out_ready)
        else $error("input blocked without a pending verdict");

    a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg && stage_beat_reg.last))
        else $error("verdict without a last byte");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> verdict_reg == pgmnak_pkg::V_MALFORMED
                          || verdict_reg == pgmnak_pkg::V_OK
                          || verdict_reg == pgmnak_pkg::V_OVERFLOW)
        else $error("reserved verdict code");

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for pgm_nak_overflow_detector. Streams PGM packets byte by
// byte with random gaps and output stalls, predicts each verdict. Depends on pgmnak_pkg.

module tb_top;

    localparam int unsigned MAX_BYTES = 65535;

    // Per-packet verdict predictor plus the queue of verdicts still owed by the DUT.
    class verdict_board;
        logic [15:0] cnt;
        logic [15:0] sum;
        logic [7:0]  hold;
        logic        is_nak;
        logic        opt_two;
        logic [7:0]  opt_len;
        logic        ck_nz;
        logic        ovf;
        pgmnak_pkg::verdict_t verdicts_due[$];
        int          errors;
        int          bytes_in;
        int          packets_in;
        int          seen[3];

        // end-around-carry add, shared with the frame builder
        static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] w);
            int unsigned t;
            t = a + w;
            t = (t & 32'hFFFF) + (t >> 16);
            return t[15:0];
        endfunction

        function void clear();
            cnt = '0;
            sum = '0;
            hold = '0;
            is_nak = 1'b0;
            opt_two = 1'b0;
            opt_len = '0;
            ck_nz = 1'b0;
            ovf = 1'b0;
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function pgmnak_pkg::verdict_t judge();
            if (ovf)
                return pgmnak_pkg::V_MALFORMED;
            if (cnt <= pgmnak_pkg::HEADER_BYTES
                || (cnt[1:0] & pgmnak_pkg::ALIGN_MASK) != 2'd0)
                return pgmnak_pkg::V_MALFORMED;
            if (!is_nak || !opt_two)
                return pgmnak_pkg::V_MALFORMED;
            if ((cnt - pgmnak_pkg::DATA_BASE) > {8'd0, opt_len})
            begin
                if (ck_nz && sum != pgmnak_pkg::SUM_GOOD)
                    return pgmnak_pkg::V_MALFORMED;
                return pgmnak_pkg::V_OVERFLOW;
            end
            return pgmnak_pkg::V_OK;
        endfunction

        // Called for every accepted input beat
        function void take_byte(logic [7:0] b, logic last);
            bytes_in++;
            if (!ovf)
            begin
                if (cnt == pgmnak_pkg::OFF_TYPE)
                    is_nak = (b == pgmnak_pkg::NAK_TYPE);
                if ((cnt == pgmnak_pkg::OFF_CK_HI || cnt == pgmnak_pkg::OFF_CK_LO)
                    && b != 8'd0)
                    ck_nz = 1'b1;
                if (cnt == pgmnak_pkg::OFF_OPT_TYPE)
                    opt_two = (b == pgmnak_pkg::NAK_OPT_VULN);
                if (cnt == pgmnak_pkg::OFF_OPT_LEN)
                    opt_len = b;
                if (!cnt[0])
                    hold = b;
                else
                    sum = ones_add(sum, {hold, b});
                if (cnt >= MAX_BYTES)
                    ovf = 1'b1;
                else
                    cnt = cnt + 16'd1;
            end
            if (last)
            begin
                verdicts_due = {verdicts_due, judge()};
                packets_in++;
                clear();
            end
        endfunction

        // Called for every accepted output beat
        function void check_verdict(pgmnak_pkg::verdict_t v);
            pgmnak_pkg::verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                $error("verdict: unexpected beat, actual %0d", v);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (v != want)
            begin
                $error("verdict: expected %0d actual %0d", want, v);
                errors++;
            end
            if (v <= pgmnak_pkg::V_OVERFLOW)
                seen[v]++;
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] packet_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    pgmnak_pkg::verdict_t verdict;

    verdict_board sb = new;
    logic [7:0]   frame[$];
    bit           quiet = 1'b0;    // no gaps or stalls on either side while set

    always #5 clk = ~clk;

    pgm_nak_overflow_detector #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .verdict     (verdict)
    );

    // ------------------------------------------------------------------
    // Frame builder. fill < 0 gives random payload, otherwise a constant.
    // ck_mode: 0 leaves the checksum field zero, 1 writes a correct one,
    // 2 writes a corrupted one.
    // ------------------------------------------------------------------
    task automatic build_nak(input int len, input logic [7:0] typ, input logic [7:0] otype,
                             input logic [7:0] olen, input int ck_mode, input int fill);
        logic [15:0] acc;
        logic [15:0] ck;
        frame.delete();
        for (int i = 0; i < len; i++)
            frame = {frame, (fill < 0 ? 8'($urandom) : 8'(fill))};
        if (len > pgmnak_pkg::OFF_TYPE)
            frame[pgmnak_pkg::OFF_TYPE] = typ;
        if (len > pgmnak_pkg::OFF_CK_LO)
        begin
            frame[pgmnak_pkg::OFF_CK_HI] = 8'd0;
            frame[pgmnak_pkg::OFF_CK_LO] = 8'd0;
        end
        if (len > pgmnak_pkg::OFF_OPT_TYPE)
            frame[pgmnak_pkg::OFF_OPT_TYPE] = otype;
        if (len > pgmnak_pkg::OFF_OPT_LEN)
            frame[pgmnak_pkg::OFF_OPT_LEN] = olen;
        if (ck_mode != 0 && len > pgmnak_pkg::OFF_CK_LO)
        begin
            acc = '0;
            for (int i = 0; i + 1 < len; i += 2)
                acc = verdict_board::ones_add(acc, {frame[i], frame[i+1]});
            ck = ~acc;
            if (ck_mode == 2)
                ck = ck ^ 16'($urandom_range(1, 65535));
            frame[pgmnak_pkg::OFF_CK_HI] = ck[15:8];
            frame[pgmnak_pkg::OFF_CK_LO] = ck[7:0];
        end
    endtask

    // One input beat. Valid is only dropped for a gap, never between back-to-back beats.
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        packet_byte <= b;
        last_byte   <= last;
        do @(posedge clk); while (!in_ready);
        sb.take_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_beat(frame[i], i == frame.size() - 1);
    endtask

    // Input goes idle while waiting, so the last beat is not offered twice
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Random packet: mostly well-formed NAKs with random content, the rest broken or noise.
    task automatic random_packet();
        int len;
        int olen;
        int kind;
        if ($urandom_range(0, 99) < 70)
        begin
            if ($urandom_range(0, 9) == 0)
                len = 48 + 4 * $urandom_range(0, 63);
            else
                len = 48 + 4 * $urandom_range(0, 12);
            // half the time sit right at the ok/overflow boundary
            if ($urandom_range(0, 1) == 0)
                olen = $urandom_range(0, 255);
            else
                olen = (len - 36) + $urandom_range(0, 2) - 1;
            if (olen > 255)
                olen = 255;
            build_nak(len, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'(olen),
                      $urandom_range(0, 2), -1);
        end
        else
        begin
            kind = $urandom_range(0, 4);
            len  = 48 + 4 * $urandom_range(0, 12);
            case (kind)
                0: build_nak(len, 8'($urandom), pgmnak_pkg::NAK_OPT_VULN, 8'($urandom), 1, -1);
                1: build_nak(len, pgmnak_pkg::NAK_TYPE, 8'($urandom), 8'($urandom), 1, -1);
                2:
                begin
                    // length not a multiple of 4
                    len = len + $urandom_range(1, 3);
                    build_nak(len, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN,
                              8'($urandom_range(0, 4)), 1, -1);
                end
                3: build_nak($urandom_range(1, 44), pgmnak_pkg::NAK_TYPE,
                             pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, -1);
                default:
                begin
                    frame.delete();
                    len = $urandom_range(1, 64);
                    for (int i = 0; i < len; i++)
                        frame = {frame, 8'($urandom)};
                end
            endcase
        end
        send_frame();
    endtask

    // ------------------------------------------------------------------
    // Verdict receiver. Stalls are applied while a verdict is waiting, so
    // out_valid is held against a low ready.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall - 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_verdict(verdict);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int rnd_packets;
        sb.clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short and boundary lengths
        build_nak(1, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 0, -1);
        send_frame();    // lone last byte
        build_nak(44, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, -1);
        send_frame();    // exactly header size
        build_nak(45, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 0, -1);
        send_frame();    // odd trailing byte
        build_nak(46, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, -1);
        send_frame();
        // minimum good length, ok/overflow edges, all-zero and all-ones payloads
        build_nak(48, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd255, 0, 0);
        send_frame();
        build_nak(48, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd11, 0, 8'hFF);
        send_frame();
        build_nak(48, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd12, 1, -1);
        send_frame();
        // overflow with good and with corrupted checksum; ok ignores a bad checksum
        build_nak(52, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, 8'hFF);
        send_frame();
        build_nak(52, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 2, -1);
        send_frame();
        build_nak(52, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd200, 2, -1);
        send_frame();
        // wrong type, wrong option type
        build_nak(56, 8'd7, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, -1);
        send_frame();
        build_nak(56, 8'hFF, pgmnak_pkg::NAK_OPT_VULN, 8'd0, 1, -1);
        send_frame();
        build_nak(56, pgmnak_pkg::NAK_TYPE, 8'd3, 8'd0, 1, -1);
        send_frame();
        build_nak(48, 8'hFF, 8'hFF, 8'hFF, 0, 8'hFF);
        send_frame();

        // sender holds off until the DUT is fully drained
        wait_drained();
        build_nak(48, pgmnak_pkg::NAK_TYPE, pgmnak_pkg::NAK_OPT_VULN, 8'd5, 1, -1);
        send_frame();

        // Random part
        rnd_packets = 0;
        while (sb.bytes_in < 1400)
        begin
            if (rnd_packets % 8 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0)
                wait_drained();
            random_packet();
            rnd_packets++;
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("verdict: %0d expected beats never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d bytes in %0d packets with random gaps and output stalls.",
                 sb.bytes_in, sb.packets_in);
        $display("Verdicts seen: malformed %0d, ok %0d, overflow %0d.",
                 sb.seen[pgmnak_pkg::V_MALFORMED], sb.seen[pgmnak_pkg::V_OK],
                 sb.seen[pgmnak_pkg::V_OVERFLOW]);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
